// File: rtl/kwm_pkg.sv
// Package for the k-way sorted merge block.
// Holds the command and status bundles shared by the controller, the datapath and the top level.
// Depends on nothing.
package kwm_pkg;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;     // Input transaction taken this cycle.
    logic scan_init;  // Restart the minimum search.
    logic scan_step;  // Read one held head and advance the scan index.
    logic load_min;   // Load the minimum, or the done mark, into the output register.
    logic load_err;   // Load an order error result into the output register.
  } kwm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_err;     // Current input comes from an unexpected list.
    logic in_go;      // Current input completes a step that needs a new minimum.
    logic scan_last;  // Scan index points at the last active list.
    logic out_free;   // Output register can take a result this cycle.
  } kwm_sts_t;

endpackage : kwm_pkg

// File: rtl/kwm_ctrl.sv
// Controller state machine of the k-way sorted merge block.
// Sequences input acceptance, the head scan and result loading.
// Depends on kwm_pkg.
module kwm_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  kwm_pkg::kwm_sts_t sts_i,
  output kwm_pkg::kwm_cmd_t cmd_o
);
  import kwm_pkg::*;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_SCAN     = 3'd1;
  localparam logic [2:0] ST_DRAIN    = 3'd2;
  localparam logic [2:0] ST_EMIT_MIN = 3'd3;
  localparam logic [2:0] ST_EMIT_ERR = 3'd4;

  logic [2:0] state_q, state_d;

  // Next state and command decode.
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept    = 1'b1;
          cmd_o.scan_init = 1'b1;
          if (sts_i.in_err) begin
            state_d = ST_EMIT_ERR;
          end else if (sts_i.in_go) begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // The last head read is compared in this cycle.
        state_d = ST_EMIT_MIN;
      end
      ST_EMIT_MIN: begin
        if (sts_i.out_free) begin
          cmd_o.load_min = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_EMIT_ERR: begin
        if (sts_i.out_free) begin
          cmd_o.load_err = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule : kwm_ctrl

// File: rtl/kwm_datapath.sv
// Datapath of the k-way sorted merge block.
// Holds the list heads, the answer and valid bits, the minimum search and the output register.
// Depends on kwm_pkg.
module kwm_datapath #(
  parameter int MAX_LISTS  = 8,
  parameter int VALUE_BITS = 32,
  localparam int LIST_W    = (MAX_LISTS > 1) ? $clog2(MAX_LISTS) : 1,
  localparam int CNT_W     = $clog2(MAX_LISTS + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CNT_W-1:0]      cfg_wdata_i,
  input  logic [LIST_W-1:0]     in_src_i,
  input  logic [VALUE_BITS-1:0] in_value_i,
  input  logic                  in_end_i,
  input  kwm_pkg::kwm_cmd_t     cmd_i,
  output kwm_pkg::kwm_sts_t     sts_o,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [VALUE_BITS-1:0] out_value_o,
  output logic [LIST_W-1:0]     out_list_o,
  output logic                  out_done_o,
  output logic                  out_err_o
);
  import kwm_pkg::*;

  logic [CNT_W-1:0]      active_q;
  logic [CNT_W-1:0]      list_cnt;
  logic [LIST_W-1:0]     last_idx;
  logic [MAX_LISTS-1:0]  act_mask;
  logic [MAX_LISTS-1:0]  src_oh;
  logic                  src_ge_n;
  logic                  all_answered;
  logic                  in_err;
  logic                  in_ok;

  logic [MAX_LISTS-1:0]  valid_q;
  logic [MAX_LISTS-1:0]  answered_q;
  logic [LIST_W-1:0]     exp_q;
  logic                  phase_q;

  logic [VALUE_BITS-1:0] head_mem [MAX_LISTS];
  logic [VALUE_BITS-1:0] rd_q;
  logic [LIST_W-1:0]     idx_q;
  logic                  cmp_v_q;
  logic [LIST_W-1:0]     cmp_idx_q;
  logic                  cmp_hit;
  logic                  found_q;
  logic [VALUE_BITS-1:0] best_val_q;
  logic [LIST_W-1:0]     best_idx_q;

  logic                  out_valid_q;
  logic [VALUE_BITS-1:0] out_value_q;
  logic [LIST_W-1:0]     out_list_q;
  logic                  out_done_q;
  logic                  out_err_q;

  // Active list count, with zero taken as one and large values clamped.
  always_comb begin
    if (active_q == '0) begin
      list_cnt = CNT_W'(1);
    end else if (active_q > CNT_W'(MAX_LISTS)) begin
      list_cnt = CNT_W'(MAX_LISTS);
    end else begin
      list_cnt = active_q;
    end
  end

  assign last_idx = LIST_W'(list_cnt - CNT_W'(1));

  // Per-list masks for the active set and the source of the current input.
  always_comb begin
    for (int i = 0; i < MAX_LISTS; i++) begin
      act_mask[i] = (CNT_W'(i) < list_cnt);
      src_oh[i]   = (in_src_i == LIST_W'(i));
    end
  end

  assign src_ge_n     = (CNT_W'(in_src_i) >= list_cnt);
  assign all_answered = (((answered_q | src_oh) & act_mask) == act_mask);

  // Input checks: fill phase takes each active list once, merge phase only the named list.
  always_comb begin
    if (phase_q) begin
      in_err = src_ge_n || (in_src_i != exp_q);
    end else begin
      in_err = src_ge_n || (|(answered_q & src_oh));
    end
  end

  assign in_ok = cmd_i.accept && !in_err;

  assign cmp_hit = cmp_v_q && valid_q[cmp_idx_q] &&
                   (!found_q || ($signed(rd_q) < $signed(best_val_q)));

  always_comb begin
    sts_o           = '0;
    sts_o.in_err    = in_err;
    sts_o.in_go     = phase_q || all_answered;
    sts_o.scan_last = (idx_q == last_idx);
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

  // Merge state: configuration, answer bits, valid bits, expected list and phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= CNT_W'(MAX_LISTS);
      valid_q    <= '0;
      answered_q <= '0;
      exp_q      <= '0;
      phase_q    <= 1'b0;
    end else if (cfg_we_i) begin
      active_q   <= cfg_wdata_i;
      valid_q    <= '0;
      answered_q <= '0;
      exp_q      <= '0;
      phase_q    <= 1'b0;
    end else if (in_ok) begin
      answered_q[in_src_i] <= 1'b1;
      valid_q[in_src_i]    <= !in_end_i;
    end else if (cmd_i.load_min) begin
      if (found_q) begin
        valid_q[best_idx_q] <= 1'b0;
        exp_q               <= best_idx_q;
        phase_q             <= 1'b1;
      end else begin
        valid_q    <= '0;
        answered_q <= '0;
        exp_q      <= '0;
        phase_q    <= 1'b0;
      end
    end
  end

  // Head storage: written by accepted elements, read one entry per scan step.
  always_ff @(posedge clk_i) begin
    if (in_ok && !in_end_i) begin
      head_mem[in_src_i] <= in_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_step) begin
      rd_q <= head_mem[idx_q];
    end
  end

  // Scan control: index, compare stage valid and found flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      cmp_v_q <= 1'b0;
      found_q <= 1'b0;
    end else begin
      cmp_v_q <= cmd_i.scan_step;
      if (cmd_i.scan_init) begin
        idx_q   <= '0;
        found_q <= 1'b0;
      end else begin
        if (cmd_i.scan_step) begin
          idx_q <= idx_q + LIST_W'(1);
        end
        if (cmp_hit) begin
          found_q <= 1'b1;
        end
      end
    end
  end

  // Running minimum; strict less-than keeps the lowest index on ties.
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_step) begin
      cmp_idx_q <= idx_q;
    end
    if (cmp_hit) begin
      best_val_q <= rd_q;
      best_idx_q <= cmp_idx_q;
    end
  end

  // Output register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_min || cmd_i.load_err) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_err) begin
      out_value_q <= '0;
      out_list_q  <= '0;
      out_done_q  <= 1'b0;
      out_err_q   <= 1'b1;
    end else if (cmd_i.load_min) begin
      out_value_q <= found_q ? best_val_q : '0;
      out_list_q  <= found_q ? best_idx_q : '0;
      out_done_q  <= !found_q;
      out_err_q   <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_list_o  = out_list_q;
  assign out_done_o  = out_done_q;
  assign out_err_o   = out_err_q;

endmodule : kwm_datapath

// File: rtl/k_way_sorted_merge_top.sv
// Top level of the k-way sorted merge block.
// Instantiates kwm_ctrl and kwm_datapath; depends on kwm_pkg.
//
// Merges up to MAX_LISTS ascending streams of signed values into one ascending stream. In the
// fill phase each active list sends its first element or an end mark (tlast) in any order, with
// the list index on tuser. Once all have answered, each output transaction carries the smallest
// held head and its list (ties go to the lowest index); that list must send next. A result with
// tlast set marks the merge done and the block clears itself; a result with the error bit set
// means the input came from an unexpected list and was ignored. A write on cfg_we_i sets the
// number of active lists (zero acts as one, values above MAX_LISTS act as MAX_LISTS) and restarts
// the merge. A fill input that does not complete the set is accepted while the controller stays
// idle with s_axis_tready high. A rejected input is accepted, then its error result is loaded.
// Every other input is accepted, then the head of each active list is read from the head store
// and compared in turn, the last compare completes, and the output register is loaded. Loading
// a result waits while the output register still holds a transaction not taken by m_axis_tready.
// The next input is taken only once the result is loaded; a single compare unit walks the heads.
module k_way_sorted_merge_top #(
  parameter int MAX_LISTS  = 8,
  parameter int VALUE_BITS = 32,
  localparam int LIST_W    = (MAX_LISTS > 1) ? $clog2(MAX_LISTS) : 1,
  localparam int CNT_W     = $clog2(MAX_LISTS + 1),
  localparam int DATA_W    = ((VALUE_BITS + 7) / 8) * 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Configuration: active list count.
  input  logic              cfg_we_i,
  input  logic [CNT_W-1:0]  cfg_wdata_i,
  // Input stream.
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [DATA_W-1:0] s_axis_tdata,   // value
  input  logic [LIST_W-1:0] s_axis_tuser,   // src
  input  logic              s_axis_tlast,   // is_end
  // Output stream.
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [DATA_W-1:0] m_axis_tdata,   // min_value
  output logic [LIST_W:0]   m_axis_tuser,   // from_list, order_error
  output logic              m_axis_tlast    // merge_done
);
  import kwm_pkg::*;

  kwm_cmd_t              cmd;
  kwm_sts_t              sts;
  logic [VALUE_BITS-1:0] out_value;
  logic [LIST_W-1:0]     out_list;
  logic                  out_err;

  kwm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  kwm_datapath #(
    .MAX_LISTS  (MAX_LISTS),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_src_i    (s_axis_tuser),
    .in_value_i  (s_axis_tdata[VALUE_BITS-1:0]),
    .in_end_i    (s_axis_tlast),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_value_o (out_value),
    .out_list_o  (out_list),
    .out_done_o  (m_axis_tlast),
    .out_err_o   (out_err)
  );

  // Pack the result fields onto the output stream.
  assign m_axis_tdata = DATA_W'(out_value);
  assign m_axis_tuser = {out_err, out_list};

`ifndef SYNTHESIS
  // A rejected input must leave the controller busy until its error result is loaded.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && sts.in_err) |=> !s_axis_tready)
    else $error("order error input did not stall the input side");

  // A result is only loaded when the output register can take it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.load_min || cmd.load_err) |-> sts.out_free)
    else $error("result loaded over a pending output transaction");

  // A loaded result shows up on the output in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.load_min || cmd.load_err) |=> m_axis_tvalid)
    else $error("loaded result not presented");

  // A result never reports done and an order error together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tlast && m_axis_tuser[LIST_W]))
    else $error("done and order error set in one result");
`endif

endmodule : k_way_sorted_merge_top

// File: tb/k_way_sorted_merge_top_test.sv
// Self-checking testbench for k_way_sorted_merge_top: directed rows, then random sorted merges.
// Expected results come from a behavioral merge predictor kept in step with accepted inputs.
// Depends only on the RTL of the block under test.
module k_way_sorted_merge_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_LISTS    = 8;
  localparam int CYCLE_LIMIT  = 500_000;
  localparam int RANDOM_ITEMS = 800;
  localparam int LONG_STALL   = 400;
  localparam int SETTLE       = 16;
  localparam int NUM_ROWS     = 25;

  // One output transaction: min_value, from_list, merge_done, order_error.
  typedef struct packed {
    logic [31:0] min_value;
    logic [2:0]  from_list;
    logic        done;
    logic        err;
  } merge_res_t;

  localparam merge_res_t NO_RES   = '0;
  localparam merge_res_t ERR_RES  = {32'd0, 3'd0, 1'b0, 1'b1};
  localparam merge_res_t DONE_RES = {32'd0, 3'd0, 1'b1, 1'b0};

  localparam bit ROW_ITEM = 1'b0;
  localparam bit ROW_CFG  = 1'b1;

  // One directed step: a register write or an input transaction.
  typedef struct packed {
    bit          kind;
    logic [3:0]  cfg_value;
    logic [2:0]  src;
    logic [31:0] value;
    bit          is_end;
    bit          has_fixed;
    merge_res_t  fixed;
  } dir_row_t;

  localparam dir_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    // Two lists; source out of range, repeated answer, wrong list, extreme values.
    '{ROW_CFG,  4'd2,  3'd0, 32'd0,          1'b0, 1'b0, NO_RES},
    '{ROW_ITEM, 4'd0,  3'd2, 32'd0,          1'b0, 1'b1, ERR_RES},
    '{ROW_ITEM, 4'd0,  3'd0, 32'h7FFF_FFFF,  1'b0, 1'b0, NO_RES},
    '{ROW_ITEM, 4'd0,  3'd0, 32'd1,          1'b0, 1'b1, ERR_RES},
    '{ROW_ITEM, 4'd0,  3'd1, 32'h8000_0000,  1'b0, 1'b0, NO_RES},
    '{ROW_ITEM, 4'd0,  3'd0, 32'd5,          1'b0, 1'b1, ERR_RES},
    '{ROW_ITEM, 4'd0,  3'd1, 32'hFFFF_FFFF,  1'b0, 1'b0, NO_RES},
    '{ROW_ITEM, 4'd0,  3'd1, 32'd0,          1'b1, 1'b0, NO_RES},
    '{ROW_ITEM, 4'd0,  3'd0, 32'd0,          1'b1, 1'b1, DONE_RES},
    // A count of zero acts as one list; an empty merge finishes at once.
    '{ROW_CFG,  4'd0,  3'd0, 32'd0,          1'b0, 1'b0, NO_RES},
    '{ROW_ITEM, 4'd0,  3'd1, 32'd9,          1'b0, 1'b1, ERR_RES},
    '{ROW_ITEM, 4'd0,  3'd0, 32'd0,          1'b1, 1'b1, DONE_RES},
    // Three equal heads go to the lowest list, then a write abandons the merge.
    '{ROW_CFG,  4'd3,  3'd0, 32'd0,          1'b0, 1'b0, NO_RES},
    '{ROW_ITEM, 4'd0,  3'd2, 32'd7,          1'b0, 1'b0, NO_RES},
    '{ROW_ITEM, 4'd0,  3'd0, 32'd7,          1'b0, 1'b0, NO_RES},
    '{ROW_ITEM, 4'd0,  3'd1, 32'd7,          1'b0, 1'b0, NO_RES},
    // A count above the maximum acts as the maximum; all eight lists are empty.
    '{ROW_CFG,  4'd15, 3'd0, 32'd0,          1'b0, 1'b0, NO_RES},
    '{ROW_ITEM, 4'd0,  3'd7, 32'd0,          1'b1, 1'b0, NO_RES},
    '{ROW_ITEM, 4'd0,  3'd6, 32'd0,          1'b1, 1'b0, NO_RES},
    '{ROW_ITEM, 4'd0,  3'd5, 32'd0,          1'b1, 1'b0, NO_RES},
    '{ROW_ITEM, 4'd0,  3'd4, 32'd0,          1'b1, 1'b0, NO_RES},
    '{ROW_ITEM, 4'd0,  3'd3, 32'd0,          1'b1, 1'b0, NO_RES},
    '{ROW_ITEM, 4'd0,  3'd2, 32'd0,          1'b1, 1'b0, NO_RES},
    '{ROW_ITEM, 4'd0,  3'd1, 32'd0,          1'b1, 1'b0, NO_RES},
    '{ROW_ITEM, 4'd0,  3'd0, 32'd0,          1'b1, 1'b1, DONE_RES}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [3:0]  cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // value
  logic [2:0]  s_axis_tuser;   // src
  logic        s_axis_tlast;   // is_end
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // min_value
  logic [3:0]  m_axis_tuser;   // from_list, order_error
  logic        m_axis_tlast;   // merge_done

  k_way_sorted_merge_top #(
    .MAX_LISTS (MAX_LISTS),
    .VALUE_BITS(32)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state: the active count register, the held list heads and the merge progress.
  logic [3:0]  active_cfg;
  logic [31:0] held_value [MAX_LISTS];
  bit          held_valid [MAX_LISTS];
  bit          answered   [MAX_LISTS];
  logic [2:0]  next_list;
  bit          merging;

  merge_res_t  pending_results [$];
  int          mismatch_count;
  int          cycle_count;
  int          items_sent, directed_items, merges_run, cfg_writes;
  int          results_checked, error_results, done_results;
  bit          sender_calm, receiver_calm, long_stall_req;

  function automatic int lists_in_use();
    if (active_cfg == 4'd0) return 1;
    if (active_cfg > MAX_LISTS) return MAX_LISTS;
    return int'(active_cfg);
  endfunction

  function automatic void clear_heads();
    for (int i = 0; i < MAX_LISTS; i++) begin
      held_value[i] = '0;
      held_valid[i] = 1'b0;
      answered[i]   = 1'b0;
    end
    next_list = '0;
    merging   = 1'b0;
  endfunction

  // Emit the smallest held head (lowest list on ties), or the done mark when none is held.
  function automatic merge_res_t select_min();
    merge_res_t r;
    bit         found;
    int         best;
    found = 1'b0;
    best  = 0;
    for (int i = 0; i < lists_in_use(); i++) begin
      if (held_valid[i] && (!found || $signed(held_value[i]) < $signed(held_value[best]))) begin
        best  = i;
        found = 1'b1;
      end
    end
    if (!found) begin
      clear_heads();
      return DONE_RES;
    end
    r           = '0;
    r.min_value = held_value[best];
    r.from_list = best[2:0];
    held_valid[best] = 1'b0;
    next_list   = best[2:0];
    merging     = 1'b1;
    return r;
  endfunction

  // Advance the predictor by one accepted input; returns 1 when a result follows.
  function automatic bit predict_merge_step(input logic [2:0] src, input logic [31:0] value,
                                            input bit is_end, output merge_res_t r);
    int n;
    n = lists_in_use();
    r = ERR_RES;
    if (!merging) begin
      if (int'(src) >= n || answered[src]) return 1'b1;
      answered[src]   = 1'b1;
      held_valid[src] = !is_end;
      if (!is_end) held_value[src] = value;
      for (int i = 0; i < n; i++) begin
        if (!answered[i]) return 1'b0;
      end
      r = select_min();
      return 1'b1;
    end
    if (src != next_list) return 1'b1;
    held_valid[src] = !is_end;
    if (!is_end) held_value[src] = value;
    r = select_min();
    return 1'b1;
  endfunction

  // Offer one input transaction after a random gap and record what it should produce.
  task automatic send_item(input logic [2:0] src, input logic [31:0] value, input bit is_end,
                           input bit has_fixed, input merge_res_t fixed);
    int         gap;
    merge_res_t r;
    bit         got;
    if ($urandom_range(0, 29) == 0) sender_calm = !sender_calm;
    gap = sender_calm ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tuser  <= src;
    s_axis_tlast  <= is_end;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    got = predict_merge_step(src, value, is_end, r);
    if (has_fixed) pending_results = {pending_results, fixed};
    else if (got) pending_results = {pending_results, r};
    items_sent++;
  endtask

  // Register writes only happen once the block has drained and settled.
  task automatic write_active_lists(input logic [3:0] count);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= count;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    active_cfg = count;
    clear_heads();
    cfg_writes++;
  endtask

  function automatic int draw_value(input int mode);
    case (mode)
      0: return $urandom;
      1: return $urandom_range(0, 8) - 4;
      2: begin
        case ($urandom_range(0, 4))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 0;
          3: return -1;
          default: return $urandom;
        endcase
      end
      default: return $urandom_range(0, 1000);
    endcase
  endfunction

  // An input that the block must reject: a wrong, repeated or out-of-range list.
  task automatic send_stray();
    logic [2:0] pool [$];
    logic [2:0] s;
    if (merging) begin
      do s = 3'($urandom_range(0, 7)); while (s == next_list);
    end else begin
      for (int c = 0; c < MAX_LISTS; c++) begin
        if (c >= lists_in_use() || answered[c]) pool = {pool, 3'(c)};
      end
      if (pool.size() == 0) return;
      s = pool[$urandom_range(0, pool.size() - 1)];
    end
    send_item(s, $urandom, 1'($urandom_range(0, 1)), 1'b0, NO_RES);
  endtask

  // One merge of random sorted lists; a nonzero stop_after abandons it early.
  task automatic run_merge(input int stop_after, output bit abandoned);
    int         lists [MAX_LISTS][$];
    int         order [$];
    int         len, mode, sent, fill_idx, n;
    logic [2:0] s;
    n         = lists_in_use();
    mode      = $urandom_range(0, 3);
    sent      = 0;
    fill_idx  = 0;
    abandoned = 1'b0;
    for (int i = 0; i < n; i++) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 3);
      for (int j = 0; j < len; j++) lists[i] = {lists[i], draw_value(mode)};
      lists[i].sort();
      order = {order, i};
    end
    order.shuffle();
    merges_run++;
    forever begin
      if (merging) s = next_list;
      else if (fill_idx < order.size()) s = 3'(order[fill_idx++]);
      else break;
      if (stop_after > 0 && sent == stop_after) begin
        abandoned = 1'b1;
        break;
      end
      if ($urandom_range(0, 11) == 0) send_stray();
      if (lists[s].size() > 0) send_item(s, lists[s].pop_front(), 1'b0, 1'b0, NO_RES);
      else send_item(s, $urandom, 1'b1, 1'b0, NO_RES);
      sent++;
    end
  endtask

  // Stimulus: reset, directed rows, then random merges across several list counts.
  initial begin
    int         random_start;
    bit         abandoned;
    logic [3:0] count;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    s_axis_tlast  <= 1'b0;
    active_cfg = 4'd8;
    clear_heads();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NUM_ROWS; i++) begin
      if (DIRECTED_ROWS[i].kind == ROW_CFG) write_active_lists(DIRECTED_ROWS[i].cfg_value);
      else send_item(DIRECTED_ROWS[i].src, DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].is_end,
                     DIRECTED_ROWS[i].has_fixed, DIRECTED_ROWS[i].fixed);
    end
    directed_items = items_sent;

    random_start   = items_sent;
    long_stall_req = 1'b1;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      if ($urandom_range(0, 7) == 0) count = 4'($urandom_range(0, 15));
      else count = 4'($urandom_range(1, 8));
      write_active_lists(count);
      repeat ($urandom_range(1, 4)) begin
        run_merge(($urandom_range(0, 9) == 0) ? $urandom_range(1, 10) : 0, abandoned);
        if (abandoned) break;
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (2 * SETTLE) @(posedge clk_i);
    $display("Run covered %0d input transactions (%0d directed), %0d merges, %0d register writes.",
             items_sent, directed_items, merges_run, cfg_writes);
    $display("Checked %0d output transactions, %0d order errors and %0d merge completions.",
             results_checked, error_results, done_results);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Output side: random ready gaps, calm stretches, and one long hold-off.
  initial begin
    int gap;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (long_stall_req) begin
        long_stall_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk_i);
      end
      if ($urandom_range(0, 29) == 0) receiver_calm = !receiver_calm;
      gap = receiver_calm ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  // Compare each accepted output transaction with the oldest expectation.
  always @(posedge clk_i) begin
    merge_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_checked++;
      if (m_axis_tuser[3]) error_results++;
      if (m_axis_tlast) done_results++;
      if (pending_results.size() == 0) begin
        $error("Unexpected output transaction: min_value %0d, from_list %0d, done %0b, error %0b",
               $signed(m_axis_tdata), m_axis_tuser[2:0], m_axis_tlast, m_axis_tuser[3]);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata !== want.min_value) begin
          $error("min_value: expected %0d, actual %0d", $signed(want.min_value),
                 $signed(m_axis_tdata));
          mismatch_count++;
        end
        if (m_axis_tuser[2:0] !== want.from_list) begin
          $error("from_list: expected %0d, actual %0d", want.from_list, m_axis_tuser[2:0]);
          mismatch_count++;
        end
        if (m_axis_tlast !== want.done) begin
          $error("merge_done: expected %0b, actual %0b", want.done, m_axis_tlast);
          mismatch_count++;
        end
        if (m_axis_tuser[3] !== want.err) begin
          $error("order_error: expected %0b, actual %0b", want.err, m_axis_tuser[3]);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial cycle_count = 0;

endmodule
